FILE: rtl/lphc_pkg.sv
// Shared constants, payload types and controller/datapath interface types.
package lphc_pkg;

  // Table geometry
  localparam int unsigned SLOTS      = 4096;
  localparam int unsigned IDX_W      = $clog2(SLOTS);
  localparam bit          SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

  // Key mix
  localparam int unsigned HASH_W    = 32;
  localparam int unsigned MOD_CNT_W = $clog2(HASH_W);
  localparam int unsigned SHIFT_A   = 13;
  localparam int unsigned SHIFT_B   = 15;
  localparam logic [HASH_W-1:0] MIX_MUL = 32'h5bd1e995;

  // Operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [63:0] value_in;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] value_out;
    logic        stored;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic hash1_en;
    logic mul_en;
    logic mix_en;
    logic mod_step;
    logic probe_start;
    logic sweep_start;
    logic adv;
    logic wr_en;
    logic wr_clr;
    logic pend_set;
    logic pend_hit;
    logic pend_stored;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       key_empty;
    logic       key_match;
    logic       probe_last;
    logic       mod_last;
    logic       sweep_last;
  } status_t;

endpackage

FILE: rtl/linear_probe_hash_cache.sv
// Top level of the linear-probe hash cache: controller, datapath and checks.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_i) takes one item: lookup,
//   insert or clear. Every item gives exactly one result item on the output
//   channel (out_valid_o / out_ready_i / out_o), in order.
//   Lookup and insert: the item is accepted, then decoded while the fold and
//   first xorshift are taken; then come the 32x32 multiply and the final
//   xorshift, the first slot read, and the probe of one slot after another
//   (key and value RAMs are read one slot ahead of the compare), and last the
//   result is handed to the output register.
//   When the slot count is not a power of two, the hash is reduced to a start
//   slot before the first slot read, one hash bit per cycle.
//   Clear: the key RAM is swept one slot per cycle.
//   After reset the same sweep runs over all SLOTS slots (4096 at the default
//   size) with in_ready_o low.
//   One item is worked on at a time; a new item is taken as soon as the
//   previous result sits in the output register. If the receiver stalls,
//   the result holds there and the next finished item waits until it moves.
module linear_probe_hash_cache (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lphc_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lphc_pkg::out_t out_o
);
  import lphc_pkg::*;

  cmd_t    cmd;
  status_t status;

  lphc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lphc_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cmd_i   (cmd),
    .status_o(status),
    .out_o   (out_o)
  );

  // Busy right after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // A result never reports both a hit and a store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_o.hit && out_o.stored))
    else $error("result with both hit and stored");

  // Value is zero unless the lookup hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.hit) |-> (out_o.value_out == 64'd0))
    else $error("nonzero value on a miss");

  // Slot RAMs are never written while an item can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd.wr_en)
    else $error("slot write while idle");

endmodule

FILE: rtl/lphc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module lphc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lphc_datapath.sv
// Datapath: item register, key mix, start-slot reduction, probe pointer, slot RAMs, results.
module lphc_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lphc_pkg::in_t    in_i,
  input  lphc_pkg::cmd_t   cmd_i,
  output lphc_pkg::status_t status_o,
  output lphc_pkg::out_t   out_o
);
  import lphc_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
  localparam logic [IDX_W:0]   SLOTS_EXT = (IDX_W + 1)'(SLOTS);

  in_t               item_q;
  logic [HASH_W-1:0] fold;
  logic [HASH_W-1:0] h1_q, h1_d;
  logic [HASH_W-1:0] h2_q, h2_d;
  logic [HASH_W-1:0] sh_q, sh_d;
  logic [IDX_W-1:0]  rem_q, rem_d;
  logic [IDX_W:0]    rem_sh, rem_sub;
  logic [MOD_CNT_W-1:0] modcnt_q;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [IDX_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  nxt;
  logic [IDX_W-1:0]  start_idx;
  logic [IDX_W-1:0]  rd_addr;
  logic [63:0]       rd_key, rd_val;
  logic [63:0]       key_wdata;
  out_t              pend_q, out_q;

  // Key mix: fold and xorshift, multiply, xorshift
  assign fold = item_q.key[31:0] ^ item_q.key[63:32];
  assign h1_d = fold ^ (fold >> SHIFT_A);
  assign h2_d = h1_q * MIX_MUL;
  assign sh_d = h2_q ^ (h2_q >> SHIFT_B);

  // Restoring reduction modulo the slot count, one hash bit a step
  assign rem_sh  = {rem_q, sh_q[HASH_W-1]};
  assign rem_sub = (rem_sh >= SLOTS_EXT) ? (rem_sh - SLOTS_EXT) : rem_sh;
  assign rem_d   = rem_sub[IDX_W-1:0];

  assign start_idx = SLOTS_POW2 ? sh_q[IDX_W-1:0] : rem_q;

  // Probe pointer wraps at the table end
  assign nxt     = (cur_q == LAST_IDX) ? '0 : cur_q + 1'b1;
  assign rd_addr = cmd_i.probe_start ? start_idx : nxt;

  always_comb begin
    cur_d = cur_q;
    if (cmd_i.sweep_start) begin
      cur_d = '0;
    end else if (cmd_i.probe_start) begin
      cur_d = start_idx;
    end else if (cmd_i.adv) begin
      cur_d = nxt;
    end
  end

  // Hold the pointer under reset so the boot sweep starts at slot zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else begin
      cur_q <= cur_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_i;
    end
    if (cmd_i.hash1_en) begin
      h1_q <= h1_d;
    end
    if (cmd_i.mul_en) begin
      h2_q <= h2_d;
    end
    if (cmd_i.mix_en) begin
      sh_q     <= sh_d;
      rem_q    <= '0;
      modcnt_q <= '0;
    end else if (cmd_i.mod_step) begin
      sh_q     <= {sh_q[HASH_W-2:0], 1'b0};
      rem_q    <= rem_d;
      modcnt_q <= modcnt_q + 1'b1;
    end
    if (cmd_i.probe_start) begin
      cnt_q <= '0;
    end else if (cmd_i.adv) begin
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.pend_set) begin
      pend_q.hit       <= cmd_i.pend_hit;
      pend_q.stored    <= cmd_i.pend_stored;
      pend_q.value_out <= cmd_i.pend_hit ? rd_val : 64'd0;
    end
    if (cmd_i.out_load) begin
      out_q <= pend_q;
    end
  end

  // Slot stores
  assign key_wdata = cmd_i.wr_clr ? 64'd0 : item_q.key;

  lphc_ram #(
    .WIDTH(64),
    .DEPTH(SLOTS)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(cur_q),
    .wdata_i(key_wdata),
    .raddr_i(rd_addr),
    .rdata_o(rd_key)
  );

  lphc_ram #(
    .WIDTH(64),
    .DEPTH(SLOTS)
  ) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en & ~cmd_i.wr_clr),
    .waddr_i(cur_q),
    .wdata_i(item_q.value_in),
    .raddr_i(rd_addr),
    .rdata_o(rd_val)
  );

  // Status back to the controller
  assign status_o.op         = item_q.op;
  assign status_o.key_empty  = (rd_key == 64'd0);
  assign status_o.key_match  = (rd_key == item_q.key);
  assign status_o.probe_last = (cnt_q == LAST_IDX);
  assign status_o.mod_last   = (modcnt_q == MOD_CNT_W'(HASH_W - 1));
  assign status_o.sweep_last = (cur_q == LAST_IDX);

  assign out_o = out_q;

endmodule

FILE: rtl/lphc_ctrl.sv
// Controller: sequences decode, key mix, reduction, probing, sweeps and the result handoff.
module lphc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lphc_pkg::status_t status_i,
  output lphc_pkg::cmd_t    cmd_o
);
  import lphc_pkg::*;

  typedef enum logic [3:0] {
    ST_BOOT,
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_MIX,
    ST_MOD,
    ST_START,
    ST_PROBE,
    ST_SWEEP,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_BOOT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_clr = 1'b1;
        cmd_o.adv    = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status_i.op)
          OP_LOOKUP, OP_INSERT: begin
            cmd_o.hash1_en = 1'b1;
            state_d        = ST_MUL;
          end
          OP_CLEAR: begin
            cmd_o.sweep_start = 1'b1;
            cmd_o.pend_set    = 1'b1;
            state_d           = ST_SWEEP;
          end
          default: begin
            cmd_o.pend_set = 1'b1;
            state_d        = ST_RESP;
          end
        endcase
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_MIX;
      end
      ST_MIX: begin
        cmd_o.mix_en = 1'b1;
        state_d      = SLOTS_POW2 ? ST_START : ST_MOD;
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        cmd_o.probe_start = 1'b1;
        state_d           = ST_PROBE;
      end
      ST_PROBE: begin
        if (status_i.key_empty) begin
          // Empty slot ends both searches; an insert claims it
          cmd_o.pend_set    = 1'b1;
          cmd_o.wr_en       = (status_i.op == OP_INSERT);
          cmd_o.pend_stored = (status_i.op == OP_INSERT);
          state_d           = ST_RESP;
        end else if ((status_i.op == OP_LOOKUP) && status_i.key_match) begin
          cmd_o.pend_set = 1'b1;
          cmd_o.pend_hit = 1'b1;
          state_d        = ST_RESP;
        end else if (status_i.probe_last) begin
          // Whole table probed: miss or table full
          cmd_o.pend_set = 1'b1;
          state_d        = ST_RESP;
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      ST_SWEEP: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_clr = 1'b1;
        cmd_o.adv    = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_BOOT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
